@@ rtl/dcc_pkg.sv @@
// constants, stage types and small tables for the day number / civil date converter
package dcc_pkg;

   localparam int unsigned NUM_STAGES   = 11;

   localparam int unsigned DAYS_PER_ERA = 146097;
   localparam int unsigned YEARS_PER_ERA = 400;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned MONTH_BIAS_LOW = 9;
   localparam int unsigned MONTH_BIAS_HIGH = 3;

   // day count of 1970-01-01 measured from one era before 0000-03-01
   localparam int unsigned EPOCH_OFFSET = 865565;
   // added to a signed day count so it stays positive and keeps (count + 4) mod 7
   localparam int unsigned WEEK_BIAS    = 4194306;
   localparam int unsigned WEEK_SHIFTED = 3;

   localparam logic signed [22:0] SPAN_LOW  = -23'sd719528;
   localparam logic signed [22:0] SPAN_HIGH = 23'sd2932896;

   localparam int unsigned ERA_SHIFT  = 41;
   localparam int unsigned Y400_SHIFT = 24;
   localparam int unsigned D1460_SHIFT = 29;
   localparam int unsigned D36524_SHIFT = 34;
   localparam int unsigned D365_SHIFT = 27;
   localparam int unsigned D153_SHIFT = 19;

   localparam longint unsigned Div1460  = 1460;
   localparam longint unsigned Div36524 = 36524;
   localparam longint unsigned Div153   = 153;
   localparam longint unsigned DivEra   = 146097;
   localparam longint unsigned DivYears = 400;
   localparam longint unsigned DivYear  = 365;

   localparam logic [23:0] ERA_RECIP =
      24'(((64'd1 << ERA_SHIFT) + DivEra - 64'd1) / DivEra);
   localparam logic [15:0] Y400_RECIP =
      16'(((64'd1 << Y400_SHIFT) + DivYears - 64'd1) / DivYears);
   localparam logic [18:0] D1460_RECIP =
      19'(((64'd1 << D1460_SHIFT) + Div1460 - 64'd1) / Div1460);
   localparam logic [18:0] D36524_RECIP =
      19'(((64'd1 << D36524_SHIFT) + Div36524 - 64'd1) / Div36524);
   localparam logic [18:0] D365_RECIP =
      19'(((64'd1 << D365_SHIFT) + DivYear - 64'd1) / DivYear);
   localparam logic [11:0] D153_RECIP =
      12'(((64'd1 << D153_SHIFT) + Div153 - 64'd1) / Div153);

   localparam logic [17:0] LAST_DAY_OF_ERA = 18'd146096;

   typedef struct packed {
      logic signed [22:0] count;
      logic [2:0]         wday;
      logic               err;
   } tail_type;

   typedef struct packed {
      logic               is_date;
      logic [14:0]        ypl;
      logic [5:0]         era;
      logic signed [9:0]  doy;
      logic signed [22:0] count;
      logic [22:0]        zp;
      logic               err;
      logic [23:0]        wa;
   } front1_type;

   typedef struct packed {
      logic               is_date;
      logic [8:0]         yoe;
      logic [22:0]        era_days;
      logic signed [9:0]  doy;
      logic signed [22:0] count;
      logic [22:0]        zp;
      logic               err;
      logic [23:0]        wa;
   } front2_type;

   typedef struct packed {
      logic [22:0]        zp;
      logic signed [22:0] count;
      logic [23:0]        wa;
      logic               err;
   } front3_type;

   typedef struct packed {
      logic [5:0]         era;
      logic [22:0]        zp;
      logic signed [22:0] count;
      logic [5:0]         wsum;
      logic               err;
   } era_stage_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [13:0] ybase;
      tail_type    tail;
   } doe_stage_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [6:0]  q1;
      logic [2:0]  q2;
      logic        q3;
      logic [13:0] ybase;
      tail_type    tail;
   } quot_stage_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [17:0] t;
      logic [13:0] ybase;
      tail_type    tail;
   } adj_stage_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [8:0]  yoe;
      logic [13:0] ybase;
      tail_type    tail;
   } yoe_stage_type;

   typedef struct packed {
      logic [8:0]  doy;
      logic [13:0] year;
      tail_type    tail;
   } doy_stage_type;

   typedef struct packed {
      logic [8:0]  doy;
      logic [3:0]  mp;
      logic [13:0] year;
      tail_type    tail;
   } mp_stage_type;

   typedef struct packed {
      logic signed [22:0] count;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         mday;
      logic [2:0]         wday;
      logic               err;
   } result_type;

   // days from march 1 to the first of the month, months counted from march
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         4'd12:   days = 9'd367;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic logic [1:0] centuries(input logic [8:0] yoe);
      logic [1:0] c;
      if (yoe >= 9'd300) begin
         c = 2'd3;
      end else if (yoe >= 9'd200) begin
         c = 2'd2;
      end else if (yoe >= 9'd100) begin
         c = 2'd1;
      end else begin
         c = 2'd0;
      end
      return c;
   endfunction

endpackage

@@ rtl/day_number_civil_date_conversion.sv @@
// top level of the day number / civil date converter pipeline
//
// usage:
//   req channel: req_valid / req_ready, one beat per conversion. req_type 0
//   turns req_day_count_in (days since 1970-01-01) into a civil date; req_type 1
//   turns req_year_in, req_month_in, req_mday_in into a day count.
//   rsp channel: rsp_valid / rsp_ready, one beat per request in request order,
//   with day count, year, month, day of month, weekday (sunday 0) and
//   rsp_range_error for a day count outside years 0 to 9999.
//   stages: eleven register stages, st0 to st10; a beat accepted on req moves
//   through them in order and is offered on rsp from st10.
//   throughput: one beat per cycle while rsp_ready stays high; the era, year of
//   era and month index multiplies are each given a stage of their own.
//   stall: each stage holds its beat while the next one is full and stalled;
//   empty stages keep filling, so req_ready only drops once every stage holds
//   a beat and rsp_ready is low.
//   reset: synchronous, clears all stage valid bits; no beats in flight.
module day_number_civil_date_conversion (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [22:0] req_day_count_in,
   input  logic [13:0]        req_year_in,
   input  logic [3:0]         req_month_in,
   input  logic [4:0]         req_mday_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [22:0] rsp_day_count_out,
   output logic [13:0]        rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_mday_out,
   output logic [2:0]         rsp_weekday,
   output logic               rsp_range_error
);
   import dcc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   front1_type     st0_ff, st0_in;
   front2_type     st1_ff, st1_in;
   front3_type     st2_ff, st2_in;
   era_stage_type  st3_ff, st3_in;
   doe_stage_type  st4_ff, st4_in;
   quot_stage_type st5_ff, st5_in;
   adj_stage_type  st6_ff, st6_in;
   yoe_stage_type  st7_ff, st7_in;
   doy_stage_type  st8_ff, st8_in;
   mp_stage_type   st9_ff, st9_in;
   result_type     st10_ff, st10_in;

   // stage handshake
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // front stage 1: era of the year, month offset, day count side
   logic        lt3;
   logic [30:0] y400_prod;
   logic [3:0]  shift_m;
   always_comb begin
      lt3 = (req_month_in <= 4'd2);
      st0_in.is_date = req_type;
      st0_in.ypl = 15'(req_year_in) + 15'(YEARS_PER_ERA) - 15'(lt3);
      y400_prod = 31'(st0_in.ypl) * 31'(Y400_RECIP);
      st0_in.era = 6'(y400_prod >> Y400_SHIFT);
      shift_m = lt3 ? req_month_in + 4'(MONTH_BIAS_LOW)
                    : req_month_in - 4'(MONTH_BIAS_HIGH);
      st0_in.doy = $signed(10'(month_start(shift_m)) + 10'(req_mday_in) - 10'd1);
      st0_in.count = req_day_count_in;
      st0_in.zp = 23'(req_day_count_in) + 23'(EPOCH_OFFSET);
      st0_in.err = (req_day_count_in < SPAN_LOW) || (req_day_count_in > SPAN_HIGH);
      st0_in.wa = {req_day_count_in[22], req_day_count_in} + 24'(WEEK_BIAS);
   end

   // front stage 2: year of era and days of whole eras
   always_comb begin
      st1_in.is_date = st0_ff.is_date;
      st1_in.yoe = 9'(st0_ff.ypl - 15'(st0_ff.era) * 15'(YEARS_PER_ERA));
      st1_in.era_days = 23'(st0_ff.era) * 23'(DAYS_PER_ERA);
      st1_in.doy = st0_ff.doy;
      st1_in.count = st0_ff.count;
      st1_in.zp = st0_ff.zp;
      st1_in.err = st0_ff.err;
      st1_in.wa = st0_ff.wa;
   end

   // front stage 3: day number of the date, merge of both directions
   logic [23:0] zp_sum;
   logic [22:0] zp_date;
   always_comb begin
      zp_sum = 24'(st1_ff.era_days) + 24'(st1_ff.yoe) * 24'(DAYS_PER_YEAR)
             + 24'(st1_ff.yoe >> 2) - 24'(centuries(st1_ff.yoe))
             + {{14{st1_ff.doy[9]}}, st1_ff.doy};
      zp_date = 23'(zp_sum);
      if (st1_ff.is_date) begin
         st2_in.zp = zp_date;
         st2_in.count = $signed(zp_date - 23'(EPOCH_OFFSET));
         st2_in.wa = 24'(zp_date) + 24'(WEEK_SHIFTED);
         st2_in.err = 1'b0;
      end else begin
         st2_in.zp = st1_ff.zp;
         st2_in.count = st1_ff.count;
         st2_in.wa = st1_ff.wa;
         st2_in.err = st1_ff.err;
      end
   end

   // era of the day number, octal digit sum for the weekday
   logic [46:0] era_prod;
   always_comb begin
      era_prod = 47'(st2_ff.zp) * 47'(ERA_RECIP);
      st3_in.era = 6'(era_prod >> ERA_SHIFT);
      st3_in.zp = st2_ff.zp;
      st3_in.count = st2_ff.count;
      st3_in.err = st2_ff.err;
      st3_in.wsum = 6'(st2_ff.wa[2:0]) + 6'(st2_ff.wa[5:3]) + 6'(st2_ff.wa[8:6])
                  + 6'(st2_ff.wa[11:9]) + 6'(st2_ff.wa[14:12]) + 6'(st2_ff.wa[17:15])
                  + 6'(st2_ff.wa[20:18]) + 6'(st2_ff.wa[23:21]);
   end

   // day of era, base year, weekday fold
   logic [3:0] wfold;
   always_comb begin
      st4_in.doe = 18'(st3_ff.zp - 23'(st3_ff.era) * 23'(DAYS_PER_ERA));
      st4_in.ybase = 14'(st3_ff.era) * 14'(YEARS_PER_ERA) - 14'(YEARS_PER_ERA);
      wfold = 4'(st3_ff.wsum[5:3]) + 4'(st3_ff.wsum[2:0]);
      if (wfold >= 4'd14) begin
         st4_in.tail.wday = 3'd0;
      end else if (wfold >= 4'd7) begin
         st4_in.tail.wday = 3'(wfold - 4'd7);
      end else begin
         st4_in.tail.wday = 3'(wfold);
      end
      st4_in.tail.count = st3_ff.count;
      st4_in.tail.err = st3_ff.err;
   end

   // leap corrections of the day of era
   logic [36:0] q1_prod;
   logic [36:0] q2_prod;
   always_comb begin
      q1_prod = 37'(st4_ff.doe) * 37'(D1460_RECIP);
      q2_prod = 37'(st4_ff.doe) * 37'(D36524_RECIP);
      st5_in.doe = st4_ff.doe;
      st5_in.q1 = 7'(q1_prod >> D1460_SHIFT);
      st5_in.q2 = 3'(q2_prod >> D36524_SHIFT);
      st5_in.q3 = (st4_ff.doe == LAST_DAY_OF_ERA);
      st5_in.ybase = st4_ff.ybase;
      st5_in.tail = st4_ff.tail;
   end

   always_comb begin
      st6_in.doe = st5_ff.doe;
      st6_in.t = st5_ff.doe - 18'(st5_ff.q1) + 18'(st5_ff.q2) - 18'(st5_ff.q3);
      st6_in.ybase = st5_ff.ybase;
      st6_in.tail = st5_ff.tail;
   end

   // year of era
   logic [36:0] yoe_prod;
   always_comb begin
      yoe_prod = 37'(st6_ff.t) * 37'(D365_RECIP);
      st7_in.doe = st6_ff.doe;
      st7_in.yoe = 9'(yoe_prod >> D365_SHIFT);
      st7_in.ybase = st6_ff.ybase;
      st7_in.tail = st6_ff.tail;
   end

   // day of year from march 1
   always_comb begin
      st8_in.doy = 9'(st7_ff.doe - (18'(st7_ff.yoe) * 18'(DAYS_PER_YEAR)
                 + 18'(st7_ff.yoe >> 2) - 18'(centuries(st7_ff.yoe))));
      st8_in.year = st7_ff.ybase + 14'(st7_ff.yoe);
      st8_in.tail = st7_ff.tail;
   end

   // month index from march
   logic [10:0] mp_arg;
   logic [22:0] mp_prod;
   always_comb begin
      mp_arg = 11'(st8_ff.doy) * 11'd5 + 11'd2;
      mp_prod = 23'(mp_arg) * 23'(D153_RECIP);
      st9_in.doy = st8_ff.doy;
      st9_in.mp = 4'(mp_prod >> D153_SHIFT);
      st9_in.year = st8_ff.year;
      st9_in.tail = st8_ff.tail;
   end

   // civil month, day and year, out of span clears the date
   logic [3:0] month_c;
   always_comb begin
      month_c = (st9_ff.mp < 4'd10) ? st9_ff.mp + 4'(MONTH_BIAS_HIGH)
                                    : st9_ff.mp - 4'(MONTH_BIAS_LOW);
      st10_in.count = st9_ff.tail.count;
      st10_in.wday = st9_ff.tail.wday;
      st10_in.err = st9_ff.tail.err;
      if (st9_ff.tail.err) begin
         st10_in.year = '0;
         st10_in.month = '0;
         st10_in.mday = '0;
      end else begin
         st10_in.year = st9_ff.year + 14'(month_c <= 4'd2);
         st10_in.month = month_c;
         st10_in.mday = 5'(st9_ff.doy - month_start(st9_ff.mp) + 9'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) st0_ff <= st0_in;
      if (stage_en[1]) st1_ff <= st1_in;
      if (stage_en[2]) st2_ff <= st2_in;
      if (stage_en[3]) st3_ff <= st3_in;
      if (stage_en[4]) st4_ff <= st4_in;
      if (stage_en[5]) st5_ff <= st5_in;
      if (stage_en[6]) st6_ff <= st6_in;
      if (stage_en[7]) st7_ff <= st7_in;
      if (stage_en[8]) st8_ff <= st8_in;
      if (stage_en[9]) st9_ff <= st9_in;
      if (stage_en[10]) st10_ff <= st10_in;
   end

   assign rsp_day_count_out = st10_ff.count;
   assign rsp_year_out = st10_ff.year;
   assign rsp_month_out = st10_ff.month;
   assign rsp_mday_out = st10_ff.mday;
   assign rsp_weekday = st10_ff.wday;
   assign rsp_range_error = st10_ff.err;

endmodule
